>>> hw/rtl/conv3x3_replicate_border_defines.svh
// Assertion macros used by the checker.
`ifndef CONV3X3_REPLICATE_BORDER_DEFINES_SVH
`define CONV3X3_REPLICATE_BORDER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define C3RB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define C3RB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, always checked.
`define C3RB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/c3rb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c3rb_pkg;

  localparam int PIX_W         = 16;
  localparam int TAP_W         = 16;
  localparam int PROD_W        = PIX_W + TAP_W;
  localparam int RSUM_W        = PROD_W + 2;
  localparam int SUM_W         = 36;
  localparam int COORD_W       = 6;
  localparam int KROW_W        = 3 * TAP_W;
  localparam int ORDER_W       = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_ORDER_DEF = 64;
  localparam int OFIFO_DEPTH   = 8;

  localparam logic [ORDER_W-1:0] FRAME_ORDER_RST = 7'd64;
  localparam logic [KROW_W-1:0]  KTOP_RST        = 48'h0000_0000_0000;
  localparam logic [KROW_W-1:0]  KMID_RST        = 48'h0000_0100_0000;
  localparam logic [KROW_W-1:0]  KBOT_RST        = 48'h0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ORDER = 2'd0,
    CFG_KERNEL_TOP  = 2'd1,
    CFG_KERNEL_MID  = 2'd2,
    CFG_KERNEL_BOT  = 2'd3
  } cfg_idx_t;

  typedef logic [2:0][KROW_W-1:0] kernel_t;
  typedef logic [8:0][PIX_W-1:0]  patch_t;

  typedef struct packed {
    logic               vld;
    patch_t             px;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } mac_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] filtered;
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic                    last;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/c3rb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module c3rb_ram
  import c3rb_pkg::*;
#(
  parameter  int WIDTH = 2 * PIX_W,
  parameter  int DEPTH = MAX_ORDER_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/c3rb_linebuf.sv
`timescale 1ns / 1ps
`default_nettype none

module c3rb_linebuf
  import c3rb_pkg::*;
#(
  parameter  int MAX_ORDER = MAX_ORDER_DEF,
  localparam int PW        = $clog2(MAX_ORDER)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             frame_restart,
  input  logic [PW-1:0]    last_idx,
  input  logic             credit_ok,
  output mac_req_t         req
);

  localparam int RW = 2 * PIX_W;

  // result kinds of one pixel, in emit order
  localparam int T_MAIN     = 0;
  localparam int T_ROW_END  = 1;
  localparam int T_LAST_ROW = 2;
  localparam int T_CORNER   = 3;

  logic [PW-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic           in_acc;
  logic           s1_v_r, s1_v_nxt;
  logic [PIX_W-1:0] s1_px_r;
  logic [PW-1:0]  s1_row_r, s1_col_r;
  logic [RW-1:0]  ram_rdata, ram_wdata;
  logic [3:0]     mask_r, mask_nxt, s1_mask, sel, rest;
  logic           issue, win_free, s1_move;
  logic [2:0][2:0][PIX_W-1:0] win_r, win_nxt;
  logic [PW-1:0]  w_row_r, w_col_r;
  logic           top_clamp_r, left_clamp_r;
  logic           rows_low, cols_right;
  logic [2:0][1:0] rsel, csel;

  assign sel      = mask_r & (~mask_r + 4'd1);
  assign rest     = mask_r & ~sel;
  assign issue    = (mask_r != 4'd0) && credit_ok;
  assign win_free = (mask_r == 4'd0) || (issue && (rest == 4'd0));
  assign s1_move  = s1_v_r && win_free;
  assign in_stall = s1_v_r && !win_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (frame_restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (col_r == last_idx) begin
        col_nxt = '0;
        row_nxt = (row_r == last_idx) ? '0 : row_r + PW'(1);
      end else begin
        col_nxt = col_r + PW'(1);
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
  end

  // RAM entry per column: low half row r-1, high half row r-2
  assign ram_wdata = {ram_rdata[PIX_W-1:0], s1_px_r};

  c3rb_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_ORDER)
  ) u_ram (
    .clk  (clk),
    .we   (s1_move),
    .waddr(s1_col_r),
    .wdata(ram_wdata),
    .re   (in_acc),
    .raddr(col_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    s1_mask[T_MAIN]     = (s1_row_r != '0) && (s1_col_r != '0);
    s1_mask[T_ROW_END]  = (s1_row_r != '0) && (s1_col_r == last_idx);
    s1_mask[T_LAST_ROW] = (s1_row_r == last_idx) && (s1_col_r != '0);
    s1_mask[T_CORNER]   = (s1_row_r == last_idx) && (s1_col_r == last_idx);
  end

  always_comb begin
    mask_nxt = mask_r;
    if (s1_move) begin
      mask_nxt = s1_mask;
    end else if (issue) begin
      mask_nxt = rest;
    end
  end

  always_comb begin
    win_nxt       = win_r;
    if (s1_move) begin
      win_nxt[0]    = win_r[1];
      win_nxt[1]    = win_r[2];
      win_nxt[2][0] = ram_rdata[RW-1:PIX_W];
      win_nxt[2][1] = ram_rdata[PIX_W-1:0];
      win_nxt[2][2] = s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
      mask_r <= 4'd0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      s1_v_r <= s1_v_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r  <= in_pixel;
      s1_row_r <= row_r;
      s1_col_r <= col_r;
    end
    win_r <= win_nxt;
    if (s1_move) begin
      w_row_r      <= s1_row_r;
      w_col_r      <= s1_col_r;
      top_clamp_r  <= (s1_row_r == PW'(1));
      left_clamp_r <= (s1_col_r == PW'(1));
    end
  end

  // last-row results use rows (r-1, r, r); row-end results use cols (c-1, c, c)
  always_comb begin
    rows_low   = sel[T_LAST_ROW] | sel[T_CORNER];
    cols_right = sel[T_ROW_END] | sel[T_CORNER];
    rsel[0]    = (rows_low || top_clamp_r) ? 2'd1 : 2'd0;
    rsel[1]    = rows_low ? 2'd2 : 2'd1;
    rsel[2]    = 2'd2;
    csel[0]    = (cols_right || left_clamp_r) ? 2'd1 : 2'd0;
    csel[1]    = cols_right ? 2'd2 : 2'd1;
    csel[2]    = 2'd2;
    req.vld    = issue;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        req.px[3*dy+dx] = win_r[csel[dx]][rsel[dy]];
      end
    end
    req.row  = COORD_W'(rows_low ? w_row_r : w_row_r - PW'(1));
    req.col  = COORD_W'(cols_right ? w_col_r : w_col_r - PW'(1));
    req.last = sel[T_CORNER];
  end

endmodule

`default_nettype wire

>>> hw/rtl/c3rb_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module c3rb_mac
  import c3rb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  kernel_t  kernel,
  input  mac_req_t req,
  output logic     res_vld,
  output result_t  res
);

  logic                     m1_v_r;
  logic signed [PROD_W-1:0] m1_prod_r [9];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic [COORD_W-1:0]       m1_row_r, m1_col_r;
  logic                     m1_last_r;
  logic                     m2_v_r;
  logic signed [RSUM_W-1:0] m2_sum_r [3];
  logic [COORD_W-1:0]       m2_row_r, m2_col_r;
  logic                     m2_last_r;

  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        prod_nxt[3*dy+dx] = $signed(req.px[3*dy+dx]) *
                            $signed(kernel[dy][dx*TAP_W +: TAP_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else begin
      m1_v_r <= req.vld;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      m1_prod_r[k] <= prod_nxt[k];
    end
    m1_row_r  <= req.row;
    m1_col_r  <= req.col;
    m1_last_r <= req.last;
    for (int dy = 0; dy < 3; dy++) begin
      m2_sum_r[dy] <= RSUM_W'(m1_prod_r[3*dy]) + RSUM_W'(m1_prod_r[3*dy+1]) +
                      RSUM_W'(m1_prod_r[3*dy+2]);
    end
    m2_row_r  <= m1_row_r;
    m2_col_r  <= m1_col_r;
    m2_last_r <= m1_last_r;
  end

  assign res_vld      = m2_v_r;
  assign res.filtered = SUM_W'(m2_sum_r[0]) + SUM_W'(m2_sum_r[1]) + SUM_W'(m2_sum_r[2]);
  assign res.row      = m2_row_r;
  assign res.col      = m2_col_r;
  assign res.last     = m2_last_r;

endmodule

`default_nettype wire

>>> hw/rtl/c3rb_ofifo.sv
`timescale 1ns / 1ps
`default_nettype none

module c3rb_ofifo
  import c3rb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    issue,
  output logic    credit_ok,
  input  logic    wr_vld,
  input  result_t wr_data,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  localparam int AW = $clog2(OFIFO_DEPTH);
  localparam int CW = AW + 1;

  result_t       mem_r [OFIFO_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt, used_r, used_nxt;
  logic          pop;

  // used_r counts requests issued and not yet popped, so the queue never overflows
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rptr_r];
  assign credit_ok = (used_r < CW'(OFIFO_DEPTH));
  assign cnt_nxt   = cnt_r + CW'(wr_vld) - CW'(pop);
  assign used_nxt  = used_r + CW'(issue) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
      used_r <= '0;
    end else begin
      if (wr_vld) begin
        wptr_r <= wptr_r + AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + AW'(1);
      end
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_vld) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/conv3x3_replicate_border.sv
// Path: s1 register, window, MAC registers m1 and m2, output queue, then the out_ port.
// Throughput: 1 pixel per cycle unless in_stall; a pixel that yields k results (up to 4, at
//   row ends and on the last row) holds the input while its extra results issue, set by the
//   one 9-lane MAC pipeline, a single 3x3 sum per cycle with credit. Output queue: 8 entries.
// Reset (rst_n, synchronous): positions, pipeline and queue cleared; N = 64, centre-only
//   kernel (tap 256). The line RAM is not cleared; results use only data of the frame.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_replicate_border
  import c3rb_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PIX_W-1:0] in_pixel,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] out_filtered,
  output logic [COORD_W-1:0]      out_row,
  output logic [COORD_W-1:0]      out_col,
  output logic                    out_frame_last,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [KROW_W-1:0]       cfg_wdata
);

  localparam int PW        = $clog2(MAX_ORDER);
  localparam int RST_ORDER = (int'(FRAME_ORDER_RST) > MAX_ORDER) ? MAX_ORDER
                                                                 : int'(FRAME_ORDER_RST);
  localparam logic [PW-1:0] LAST_RST = PW'(RST_ORDER - 1);

  kernel_t            kernel_r;
  logic [PW-1:0]      last_idx_r, last_wr;
  logic [ORDER_W-1:0] order_wr;
  logic               frame_restart;
  cfg_idx_t           cfg_sel;
  logic               credit_ok;
  mac_req_t           req;
  logic               res_vld;
  result_t            res, head;

  assign cfg_sel       = cfg_idx_t'(cfg_index);
  assign frame_restart = cfg_we && (cfg_sel == CFG_FRAME_ORDER);
  assign order_wr      = cfg_wdata[ORDER_W-1:0];

  always_comb begin
    if (int'(order_wr) < 2) begin
      last_wr = PW'(1);
    end else if (int'(order_wr) > MAX_ORDER) begin
      last_wr = PW'(MAX_ORDER - 1);
    end else begin
      last_wr = PW'(int'(order_wr) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r[0] <= KTOP_RST;
      kernel_r[1] <= KMID_RST;
      kernel_r[2] <= KBOT_RST;
      last_idx_r  <= LAST_RST;
    end else if (cfg_we) begin
      case (cfg_sel)
        CFG_FRAME_ORDER: last_idx_r  <= last_wr;
        CFG_KERNEL_TOP:  kernel_r[0] <= cfg_wdata;
        CFG_KERNEL_MID:  kernel_r[1] <= cfg_wdata;
        CFG_KERNEL_BOT:  kernel_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  c3rb_linebuf #(
    .MAX_ORDER(MAX_ORDER)
  ) u_linebuf (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .frame_restart(frame_restart),
    .last_idx     (last_idx_r),
    .credit_ok    (credit_ok),
    .req          (req)
  );

  c3rb_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .kernel (kernel_r),
    .req    (req),
    .res_vld(res_vld),
    .res    (res)
  );

  c3rb_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (req.vld),
    .credit_ok(credit_ok),
    .wr_vld   (res_vld),
    .wr_data  (res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (head)
  );

  assign out_filtered   = head.filtered;
  assign out_row        = head.row;
  assign out_col        = head.col;
  assign out_frame_last = head.last;

endmodule

`default_nettype wire

>>> hw/rtl/c3rb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "conv3x3_replicate_border_defines.svh"

module c3rb_checker
  import c3rb_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [SUM_W-1:0] out_filtered,
  input logic [COORD_W-1:0]      out_row,
  input logic [COORD_W-1:0]      out_col,
  input logic                    out_frame_last
);

  `C3RB_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_valid && out_stall, out_valid, "out_valid dropped while stalled")
  `C3RB_ASSERT_NEXT(a_out_payload_held, clk, rst_n, out_valid && out_stall, $stable(out_filtered) && $stable(out_row) && $stable(out_col) && $stable(out_frame_last), "output transaction changed while stalled")
  `C3RB_ASSERT_SAME(a_last_on_corner, clk, rst_n, out_valid && out_frame_last, out_row == out_col, "frame_last off the corner pixel")
  `C3RB_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind conv3x3_replicate_border c3rb_checker u_c3rb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_filtered  (out_filtered),
  .out_row       (out_row),
  .out_col       (out_col),
  .out_frame_last(out_frame_last)
);

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import c3rb_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 200;

  typedef struct {
    logic signed [PIX_W-1:0] value;
    bit                      drain;
  } pixel_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [PIX_W-1:0] in_pixel = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SUM_W-1:0] out_filtered;
  logic [COORD_W-1:0]      out_row;
  logic [COORD_W-1:0]      out_col;
  logic                    out_frame_last;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [KROW_W-1:0]       cfg_wdata = '0;

  conv3x3_replicate_border u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_filtered   (out_filtered),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic signed [PIX_W-1:0] line_mem [0:3*MAX_ORDER_DEF-1];
  logic [ORDER_W-1:0]      conv_order = FRAME_ORDER_RST;
  logic [KROW_W-1:0]       conv_kernel [0:2];
  int                      conv_row = 0;
  int                      conv_col = 0;

  pixel_item_t pixel_queue[$];
  result_t     expected_outputs[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int cycle_count = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  cfg_idx_t kernel_regs [0:2] = '{CFG_KERNEL_TOP, CFG_KERNEL_MID, CFG_KERNEL_BOT};

  initial begin
    conv_kernel[0] = KTOP_RST;
    conv_kernel[1] = KMID_RST;
    conv_kernel[2] = KBOT_RST;
    for (int i = 0; i < 3 * MAX_ORDER_DEF; i++) line_mem[i] = '0;
  end

  function automatic int order_in_use();
    int n;
    n = conv_order;
    if (n < 2) n = 2;
    if (n > MAX_ORDER_DEF) n = MAX_ORDER_DEF;
    return n;
  endfunction

  function automatic int clamp_coord(int v, int n);
    if (v < 0) return 0;
    if (v > n - 1) return n - 1;
    return v;
  endfunction

  function automatic logic signed [SUM_W-1:0] window_sum(int y, int x, int n);
    logic signed [47:0]      acc;
    logic signed [PIX_W-1:0] pix;
    logic signed [TAP_W-1:0] tap;
    logic signed [PROD_W-1:0] prod;
    int yy;
    int xx;
    acc = '0;
    for (int dy = 0; dy < 3; dy++) begin
      yy = clamp_coord(y - 1 + dy, n);
      for (int dx = 0; dx < 3; dx++) begin
        xx = clamp_coord(x - 1 + dx, n);
        pix = line_mem[(yy % 3) * MAX_ORDER_DEF + xx];
        tap = conv_kernel[dy][TAP_W*dx +: TAP_W];
        prod = pix * tap;
        acc = acc + prod;
      end
    end
    return acc[SUM_W-1:0];
  endfunction

  task automatic push_output(int y, int x, int n, logic last);
    result_t r;
    r.filtered = window_sum(y, x, n);
    r.row = y[COORD_W-1:0];
    r.col = x[COORD_W-1:0];
    r.last = last;
    expected_outputs.push_back(r);
  endtask

  task automatic predict_outputs(logic signed [PIX_W-1:0] pixel);
    int n;
    int r;
    int c;
    n = order_in_use();
    r = conv_row;
    c = conv_col;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    line_mem[(r % 3) * MAX_ORDER_DEF + c] = pixel;
    if (r >= 1 && c >= 1) push_output(r - 1, c - 1, n, 1'b0);
    if (r >= 1 && c == n - 1) push_output(r - 1, n - 1, n, 1'b0);
    if (r == n - 1 && c >= 1) push_output(n - 1, c - 1, n, 1'b0);
    if (r == n - 1 && c == n - 1) push_output(n - 1, n - 1, n, 1'b1);
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    conv_row = r;
    conv_col = c;
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Driver
  pixel_item_t drv_item;
  bit          drv_have = 1'b0;
  int          drv_gap = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_outputs(in_pixel);
        n_accepted++;
      end
      if ((in_valid && !in_stall) || !in_valid) begin
        if (!drv_have && pixel_queue.size() > 0) begin
          drv_item = pixel_queue.pop_front();
          drv_gap = tx_idle ? $urandom_range(0, 15) : 0;
          drv_have = 1'b1;
        end
        if (drv_have && drv_gap == 0 && (!drv_item.drain || expected_outputs.size() == 0)) begin
          in_valid <= 1'b1;
          in_pixel <= drv_item.value;
          drv_have = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (drv_have && drv_gap > 0) drv_gap--;
        end
      end
    end
  end

  // Monitor
  int rx_wait = 0;

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction row %0d col %0d", out_row, out_col));
        end else begin
          exp_r = expected_outputs.pop_front();
          if (out_filtered !== exp_r.filtered)
            report_mismatch($sformatf("filtered %0d, expected %0d at (%0d,%0d)",
                                      out_filtered, exp_r.filtered, exp_r.row, exp_r.col));
          if (out_row !== exp_r.row)
            report_mismatch($sformatf("out_row %0d, expected %0d", out_row, exp_r.row));
          if (out_col !== exp_r.col)
            report_mismatch($sformatf("out_col %0d, expected %0d", out_col, exp_r.col));
          if (out_frame_last !== exp_r.last)
            report_mismatch($sformatf("frame_last %0b, expected %0b at (%0d,%0d)",
                                      out_frame_last, exp_r.last, exp_r.row, exp_r.col));
        end
        rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_register(cfg_idx_t idx, logic [KROW_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_ORDER: begin
        conv_order = data[ORDER_W-1:0];
        conv_row = 0;
        conv_col = 0;
      end
      CFG_KERNEL_TOP: conv_kernel[0] = data;
      CFG_KERNEL_MID: conv_kernel[1] = data;
      CFG_KERNEL_BOT: conv_kernel[2] = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(logic signed [PIX_W-1:0] value, bit drain);
    pixel_item_t it;
    it.value = value;
    it.drain = drain;
    pixel_queue.push_back(it);
    n_queued++;
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] rand_krow();
    if ($urandom_range(0, 7) == 0) return 48'h0000_0100_0000;
    return {rand_word(), rand_word(), rand_word()};
  endfunction

  initial begin
    int n;
    int count;
    int drain_at;
    int sel;
    int phase;
    int random_items;
    logic [KROW_W-1:0] wdata;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First rows at reset settings: N = 64, centre-only kernel (tap 256), no idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 2 * MAX_ORDER_DEF + 8; i++) push_pixel(rand_word(), 1'b0);
    wait_idle();

    // Directed: 2x2 frame, extreme taps and pixels
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_register(CFG_FRAME_ORDER, 48'd2);
    write_register(CFG_KERNEL_TOP, 48'h8000_7FFF_0001);
    write_register(CFG_KERNEL_MID, 48'h7FFF_8000_FFFF);
    write_register(CFG_KERNEL_BOT, 48'h0100_0000_8000);
    push_pixel(16'sh7FFF, 1'b0);
    push_pixel(16'sh8000, 1'b0);
    push_pixel(16'sh8000, 1'b0);
    push_pixel(16'sh7FFF, 1'b0);
    wait_idle();

    // Most positive sum: all taps and pixels at the minimum
    write_register(CFG_KERNEL_TOP, 48'h8000_8000_8000);
    write_register(CFG_KERNEL_MID, 48'h8000_8000_8000);
    write_register(CFG_KERNEL_BOT, 48'h8000_8000_8000);
    for (int i = 0; i < 4; i++) push_pixel(16'sh8000, 1'b0);
    wait_idle();

    // Order below range acts as 2; upper data bits set
    write_register(CFG_FRAME_ORDER, 48'hFFFF_FFFF_FF80);
    write_register(CFG_KERNEL_MID, rand_krow());
    push_pixel(16'sh0000, 1'b0);
    push_pixel(16'shFFFF, 1'b0);
    push_pixel(16'sh0001, 1'b0);
    push_pixel(16'sh5555, 1'b0);
    wait_idle();

    // 3x3 frame with a kernel change part way through
    write_register(CFG_FRAME_ORDER, 48'd3);
    write_register(CFG_KERNEL_TOP, 48'h7FFF_7FFF_7FFF);
    write_register(CFG_KERNEL_MID, 48'h7FFF_7FFF_7FFF);
    write_register(CFG_KERNEL_BOT, 48'h7FFF_7FFF_7FFF);
    for (int i = 0; i < 5; i++) push_pixel(i[0] ? 16'sh8000 : 16'sh7FFF, 1'b0);
    wait_idle();
    write_register(CFG_KERNEL_MID, rand_krow());
    for (int i = 5; i < 9; i++) push_pixel(i[0] ? 16'sh8000 : 16'sh7FFF, 1'b0);

    // Random phases
    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 9);
        wdata = KROW_W'({$urandom, $urandom});
        if (sel < 7) wdata[ORDER_W-1:0] = ORDER_W'($urandom_range(2, 8));
        else if (sel == 7) wdata[ORDER_W-1:0] = ORDER_W'($urandom_range(0, 1));
        else if (sel == 8) wdata[ORDER_W-1:0] = ORDER_W'($urandom_range(9, 20));
        else wdata[ORDER_W-1:0] = ORDER_W'($urandom_range(64, 127));
        write_register(CFG_FRAME_ORDER, wdata);
      end
      for (int k = 0; k < 3; k++)
        if (phase == 0 || $urandom_range(0, 1) != 0) write_register(kernel_regs[k], rand_krow());
      n = order_in_use();
      if (n <= 8) count = n * n * $urandom_range(1, 3) + $urandom_range(0, n * n - 1);
      else count = 2 * n + $urandom_range(0, n);
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      drain_at = (phase % 2 == 0) ? count / 2 : -1;
      for (int i = 0; i < count; i++) push_pixel(rand_word(), i == drain_at);
      random_items += count;
      phase++;
    end

    while (n_accepted != n_queued || expected_outputs.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
